FILE: src/utf8_stream_decoder_core_macros.svh
// Assertion macros used by the decoder core.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define UTF8DEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define UTF8DEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/utf8dec_pkg.sv
`default_nettype none

package utf8dec_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int PEND_W = 2;

  // Replacement character for malformed input.
  localparam logic [CP_W-1:0] CP_REPLACEMENT = CP_W'(32'hFFFD);

  // Lead and continuation byte classification masks.
  localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

  // Number of results one byte produces.
  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_ONE  = 2'd1,
    RES_TWO  = 2'd2
  } res_count_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            run_last;
    logic            text_done;
  } result_t;

  // What the decode step hands to the result queue.
  typedef struct packed {
    res_count_t n_res;
    result_t    res0;
    result_t    res1;
  } step_t;

endpackage

`default_nettype wire

FILE: src/utf8dec_in_if.sv
`default_nettype none

interface utf8dec_in_if import utf8dec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

`default_nettype wire

FILE: src/utf8dec_out_if.sv
`default_nettype none

interface utf8dec_out_if import utf8dec_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            run_last;
  logic            text_done;

  modport source (output valid, output code_point, output run_last, output text_done,
                  input ready);
  modport sink   (input valid, input code_point, input run_last, input text_done,
                  output ready);
endinterface

`default_nettype wire

FILE: src/utf8dec_step.sv
`default_nettype none

module utf8dec_step import utf8dec_pkg::*; (
  input  wire logic [BYTE_W-1:0] text_byte,
  input  wire logic              text_last,
  input  wire logic [PEND_W-1:0] pend,
  input  wire logic [CP_W-1:0]   partial,
  output logic      [PEND_W-1:0] pend_next,
  output logic      [CP_W-1:0]   partial_next,
  output step_t                  step
);

  logic              lead_emit;
  logic [CP_W-1:0]   lead_cp;
  logic [PEND_W-1:0] lead_pend;
  logic [CP_W-1:0]   lead_part;
  logic              is_cont;
  logic [CP_W-1:0]   cont_part;
  logic [PEND_W-1:0] cont_pend;
  result_t           blank;

  // Decode the word as a lead byte from a fresh state.
  always_comb begin
    lead_emit = 1'b0;
    lead_cp   = CP_REPLACEMENT;
    lead_pend = '0;
    lead_part = '0;
    priority if ((text_byte & ASCII_MASK) == '0) begin
      lead_emit = 1'b1;
      lead_cp   = CP_W'(text_byte);
    end else if ((text_byte & LEAD2_MASK) == LEAD2_CODE) begin
      lead_pend = PEND_W'(1);
      lead_part = CP_W'(text_byte & LEAD2_BITS);
    end else if ((text_byte & LEAD3_MASK) == LEAD3_CODE) begin
      lead_pend = PEND_W'(2);
      lead_part = CP_W'(text_byte & LEAD3_BITS);
    end else if ((text_byte & LEAD4_MASK) == LEAD4_CODE) begin
      lead_pend = PEND_W'(3);
      lead_part = CP_W'(text_byte & LEAD4_BITS);
    end else begin
      lead_emit = 1'b1;
      lead_cp   = CP_REPLACEMENT;
    end
    // A multi-byte lead at the end of the text emits what it holds.
    if (!lead_emit && text_last) begin
      lead_emit = 1'b1;
      lead_cp   = lead_part;
    end
  end

  // Continuation path: shift six more bits into the partial code point.
  assign is_cont   = (text_byte & CONT_MASK) == CONT_CODE;
  assign cont_part = {partial[CP_W-7:0], 6'(text_byte & CONT_BITS)};
  assign cont_pend = pend - PEND_W'(1);

  assign blank = '{code_point: '0, run_last: 1'b0, text_done: 1'b0};

  // Select the results and the next state.
  always_comb begin
    step.n_res   = RES_NONE;
    step.res0    = blank;
    step.res1    = blank;
    pend_next    = pend;
    partial_next = partial;
    priority if (pend == '0) begin
      pend_next    = lead_pend;
      partial_next = lead_part;
      if (lead_emit) begin
        step.n_res = RES_ONE;
        step.res0  = '{code_point: lead_cp, run_last: 1'b1, text_done: text_last};
      end
    end else if (is_cont) begin
      pend_next    = cont_pend;
      partial_next = cont_part;
      if (cont_pend == '0 || text_last) begin
        step.n_res = RES_ONE;
        step.res0  = '{code_point: cont_part, run_last: 1'b1, text_done: text_last};
      end
    end else begin
      // Bad continuation: replace the sequence, then take the word as a lead.
      pend_next    = lead_pend;
      partial_next = lead_part;
      if (lead_emit) begin
        step.n_res = RES_TWO;
        step.res0  = '{code_point: CP_REPLACEMENT, run_last: 1'b0, text_done: 1'b0};
        step.res1  = '{code_point: lead_cp, run_last: 1'b1, text_done: text_last};
      end else begin
        step.n_res = RES_ONE;
        step.res0  = '{code_point: CP_REPLACEMENT, run_last: 1'b1, text_done: text_last};
      end
    end
    // The end of a text always leaves a fresh state.
    if (text_last) begin
      pend_next    = '0;
      partial_next = '0;
    end
  end

endmodule

`default_nettype wire

FILE: src/utf8_stream_decoder_core.sv
// UTF-8 stream decoder.
// The text channel carries one byte of UTF-8 text per word, with text_last
// marking the final byte of a text. The result channel carries decoded code
// points; malformed input yields U+FFFD, and a byte that breaks a pending
// sequence yields U+FFFD followed by its own decode (run_last marks the last
// result of a byte, text_done the final result of a text).
// A byte is decoded in the cycle it is accepted and its results are written
// into a three-entry result queue, from which they are offered. The block
// accepts one byte per cycle as long as the result side keeps up; the queue
// admits a byte while it holds at most one result, so a byte with two
// results holds off the next byte until a result is popped.
// When the receiver stalls, results wait in the queue and text ready drops
// once two or more are held. Synchronous reset empties the queue and clears
// the pending count and partial code point.
`default_nettype none
`include "utf8_stream_decoder_core_macros.svh"

module utf8_stream_decoder_core import utf8dec_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  utf8dec_in_if.sink  text,
  utf8dec_out_if.source result
);

  localparam int QDEPTH = 3;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  logic [PEND_W-1:0] pend;
  logic [PEND_W-1:0] pend_next;
  logic [CP_W-1:0]   partial;
  logic [CP_W-1:0]   partial_next;
  step_t             step;

  result_t           queue [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] wr_ptr_next;
  logic [QIDX_W-1:0] wr_ptr_plus1;
  logic [QIDX_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic [QCNT_W-1:0] n_push;
  logic              push;
  logic              pop;

  function automatic logic [QIDX_W-1:0] ptr_inc(input logic [QIDX_W-1:0] p);
    ptr_inc = (p == QIDX_W'(QDEPTH - 1)) ? '0 : p + QIDX_W'(1);
  endfunction

  utf8dec_step u_step (
    .text_byte    (text.text_byte),
    .text_last    (text.text_last),
    .pend         (pend),
    .partial      (partial),
    .pend_next    (pend_next),
    .partial_next (partial_next),
    .step         (step)
  );

  // Handshakes: room for two results lets any byte in.
  assign text.ready = (count <= QCNT_W'(QDEPTH - 2));
  assign push       = text.valid && text.ready;
  assign pop        = result.valid && result.ready;

  assign n_push       = push ? QCNT_W'(step.n_res) : '0;
  assign count_next   = count + n_push - QCNT_W'(pop);
  assign wr_ptr_plus1 = ptr_inc(wr_ptr);

  always_comb begin
    unique case (step.n_res)
      RES_ONE: wr_ptr_next = push ? wr_ptr_plus1 : wr_ptr;
      RES_TWO: wr_ptr_next = push ? ptr_inc(wr_ptr_plus1) : wr_ptr;
      default: wr_ptr_next = wr_ptr;
    endcase
  end

  // Decoder state and queue control.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= '0;
      partial <= '0;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
    end else begin
      if (push) begin
        pend    <= pend_next;
        partial <= partial_next;
      end
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push && step.n_res != RES_NONE) begin
      queue[wr_ptr] <= step.res0;
    end
    if (push && step.n_res == RES_TWO) begin
      queue[wr_ptr_plus1] <= step.res1;
    end
  end

  assign result.valid      = (count != '0);
  assign result.code_point = queue[rd_ptr].code_point;
  assign result.run_last   = queue[rd_ptr].run_last;
  assign result.text_done  = queue[rd_ptr].text_done;

  // Checks.
  `UTF8DEC_ASSERT_NOW(a_done_is_run_last, result.valid && result.text_done,
    result.run_last, "text_done result is not the last of its byte")
  `UTF8DEC_ASSERT_NEXT(a_last_clears_state, push && text.text_last,
    pend == '0 && partial == '0, "state not cleared after end of text")
  `UTF8DEC_ASSERT_NEXT(a_count_tracks, 1'b1,
    count == $past(count) + $past(n_push) - QCNT_W'($past(pop)),
    "queue count does not match pushes and pops")
  `UTF8DEC_ASSERT_NOW(a_count_bound, 1'b1, count <= QCNT_W'(QDEPTH),
    "result queue overflow")

endmodule

`default_nettype wire

FILE: bench/utf8_stream_decoder_core_tb.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_core_tb;
  import utf8dec_pkg::*;

  // Tracks the decoder state and holds the code points still owed by the block.
  class code_point_board;
    logic [PEND_W-1:0] cont_left;
    logic [CP_W-1:0]   partial;
    result_t           owed_q[$];
    int                errors;
    int                n_bytes;
    int                n_results;
    int                n_repl;
    int                n_double;

    function new();
      cont_left = '0;
      partial   = '0;
      errors    = 0;
      n_bytes   = 0;
      n_results = 0;
      n_repl    = 0;
      n_double  = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void owe(logic [CP_W-1:0] cp, logic run_last, logic text_done);
      result_t r;
      r.code_point = cp;
      r.run_last   = run_last;
      r.text_done  = text_done;
      owed_q.push_back(r);
      if (cp == CP_REPLACEMENT) n_repl++;
    endfunction

    // Decodes a byte as the start of a sequence. Returns 1 with cp set when
    // the byte completes a result on its own.
    function bit take_lead(logic [BYTE_W-1:0] b, logic last, output logic [CP_W-1:0] cp);
      cp = CP_REPLACEMENT;
      if ((b & ASCII_MASK) == '0) begin
        cp = CP_W'(b);
        return 1'b1;
      end
      if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        partial   = CP_W'(b & LEAD2_BITS);
        cont_left = 2'd1;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        partial   = CP_W'(b & LEAD3_BITS);
        cont_left = 2'd2;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
        partial   = CP_W'(b & LEAD4_BITS);
        cont_left = 2'd3;
      end else begin
        return 1'b1;
      end
      // A text that ends on a lead byte flushes what was gathered.
      cp = partial;
      return last;
    endfunction

    // Works out the results that one accepted text word causes.
    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      logic [CP_W-1:0] cp;
      n_bytes++;
      if (cont_left == '0) begin
        if (take_lead(b, last, cp)) owe(cp, 1'b1, last);
      end else if ((b & CONT_MASK) == CONT_CODE) begin
        partial   = (partial << 6) | CP_W'(b & CONT_BITS);
        cont_left = cont_left - 2'd1;
        if (cont_left == '0 || last) owe(partial, 1'b1, last);
      end else begin
        // A broken sequence gives a replacement, then the byte starts over.
        cont_left = '0;
        partial   = '0;
        if (take_lead(b, last, cp)) begin
          owe(CP_REPLACEMENT, 1'b0, 1'b0);
          owe(cp, 1'b1, last);
          n_double++;
        end else begin
          owe(CP_REPLACEMENT, 1'b1, last);
        end
      end
      if (last) begin
        cont_left = '0;
        partial   = '0;
      end
    endfunction

    // Compares an accepted result word with the oldest owed code point.
    function void check_result(logic [CP_W-1:0] cp, logic run_last, logic text_done);
      result_t want;
      n_results++;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result code_point=%h run_last=%b text_done=%b",
                 $time, cp, run_last, text_done);
        return;
      end
      want = owed_q.pop_front();
      if (want.code_point !== cp) begin
        errors++;
        $display("%0t: code_point expected %h, got %h", $time, want.code_point, cp);
      end
      if (want.run_last !== run_last) begin
        errors++;
        $display("%0t: run_last expected %b, got %b (code_point %h)",
                 $time, want.run_last, run_last, cp);
      end
      if (want.text_done !== text_done) begin
        errors++;
        $display("%0t: text_done expected %b, got %b (code_point %h)",
                 $time, want.text_done, text_done, cp);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  utf8dec_in_if  text ();
  utf8dec_out_if result ();

  utf8_stream_decoder_core dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .result (result)
  );

  code_point_board board = new();

  bit no_idle;
  bit hold_req;
  logic [BYTE_W-1:0] text_bytes[$];

  always #2 clk = ~clk;

  // Accepted words on both channels feed the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (text.valid && text.ready) board.note_byte(text.text_byte, text.text_last);
      if (result.valid && result.ready)
        board.check_result(result.code_point, result.run_last, result.text_done);
    end
  end

  // Mostly short gaps, a few long ones, none while a quiet stretch runs.
  function int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // Appends the first keep bytes of a random well-formed character of len bytes.
  function void add_char(int len, int keep);
    logic [BYTE_W-1:0] seq[4];
    case (len)
      1: seq[0] = {1'b0, 7'($urandom)};
      2: seq[0] = {3'b110, 5'($urandom)};
      3: seq[0] = {4'b1110, 4'($urandom)};
      default: seq[0] = {5'b11110, 3'($urandom)};
    endcase
    for (int i = 1; i < 4; i++) seq[i] = {2'b10, 6'($urandom)};
    for (int i = 0; i < keep; i++) text_bytes.push_back(seq[i]);
  endfunction

  // Builds one text: mostly whole characters, with noise and cut sequences.
  function void build_text();
    int n_chars;
    int kind;
    int len;
    text_bytes.delete();
    n_chars = $urandom_range(1, 10);
    repeat (n_chars) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        len = $urandom_range(1, 4);
        add_char(len, len);
      end else if (kind < 85) begin
        text_bytes.push_back(8'($urandom));
      end else if (kind < 95) begin
        len = $urandom_range(2, 4);
        add_char(len, $urandom_range(1, len - 1));
      end else begin
        text_bytes.push_back({2'b10, 6'($urandom)});
      end
    end
  endfunction

  // Offers one text word and returns at the edge where it is taken.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      text.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    text.valid     <= 1'b1;
    text.text_byte <= b;
    text.text_last <= last;
    do @(posedge clk); while (!text.ready);
  endtask

  // Stops offering and waits until every owed code point has come out.
  task automatic wait_drained();
    @(negedge clk);
    text.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result.ready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          result.ready <= 1'b1;
        end else begin
          result.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin
    int  sent;
    bit  held;
    bit  paused;
    text.valid     = 1'b0;
    text.text_byte = '0;
    text.text_last = 1'b0;
    rst            = 1'b1;
    no_idle        = 1'b1;
    hold_req       = 1'b0;
    sent           = 0;
    held           = 1'b0;
    paused         = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed texts: ASCII extremes and each sequence length.
    send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // Invalid lead bytes.
    send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hF8, 1'b0);
    // Broken sequences: followed by ASCII, by a new lead, by an invalid lead.
    send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hFF, 1'b0);
    // Texts that end on a lead byte, mid-sequence, and on a broken sequence.
    send_byte(8'hC3, 1'b1);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
    send_byte(8'hD0, 1'b0); send_byte(8'h7A, 1'b1);
    wait_drained();

    // Random texts with a long result hold-off and one full drain midway.
    while (sent < 550) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (!held && sent >= 150) begin
        held     = 1'b1;
        no_idle  = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent >= 350) begin
        paused = 1'b1;
        wait_drained();
      end
      build_text();
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
      sent += text_bytes.size();
    end
    wait_drained();

    $display("Decoded %0d bytes into %0d code points: %0d replacements, %0d two-result bytes.",
             board.n_bytes, board.n_results, board.n_repl, board.n_double);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("utf8_stream_decoder_core_tb passed");
    end else begin
      $display("utf8_stream_decoder_core_tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("utf8_stream_decoder_core_tb failed");
    $finish;
  end

endmodule

FILE: utf8_stream_decoder_core.f
+incdir+src
src/utf8dec_pkg.sv
src/utf8dec_in_if.sv
src/utf8dec_out_if.sv
src/utf8dec_step.sv
src/utf8_stream_decoder_core.sv
bench/utf8_stream_decoder_core_tb.sv
